### hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared opcodes, status codes and the command/status structs that join the
// deque controller to its datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic       load;        // latch opcode/value, clear dump offset
    logic       wr_front;    // push at front
    logic       wr_back;     // push at back
    logic       rm_front;    // drop front entry
    logic       rm_back;     // drop back entry
    logic       rd_front;    // read front entry
    logic       rd_back;     // read back entry
    logic       rd_dump;     // read entry at dump offset, advance offset
    logic       emit;        // load output register
    logic       emit_data;   // result takes read data, else zero
    logic [1:0] emit_status;
    logic       emit_last;
  } bdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       dump_last;   // entry now being shown is the back one
  } bdq_stat_t;

endpackage

### hdl/bdq_datapath.sv
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, front index, entry count, dump offset and the result register.
// ----------------------------------------------------------------------------
module bdq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [2:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  bdq_pkg::bdq_cmd_t            cmd,
  output bdq_pkg::bdq_stat_t           stat,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_result_value,
  output logic [1:0]                   out_status,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count,
  output logic                         out_last_of_run
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [2:0]            op_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [IW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         dcnt_r, dcnt_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_value_r;
  logic [1:0]            out_status_r;
  logic [CW-1:0]         out_count_r;
  logic                  out_last_r;

  logic [CW-1:0] offset;
  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;
  logic [IW-1:0] ring_pos;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          wr_en;
  logic          rd_en;

  // one ring adder: front + offset mod DEPTH
  always_comb begin
    if (cmd.wr_back) begin
      offset = count_r;
    end else if (cmd.rd_back) begin
      offset = count_r - CW'(1);
    end else if (cmd.rd_dump) begin
      offset = dcnt_r;
    end else begin
      offset = CW'(1);
    end
    sum      = SW'(front_r) + SW'(offset);
    wrapped  = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    ring_pos = wrapped[IW-1:0];
  end

  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - IW'(1);

  assign wr_en   = cmd.wr_front | cmd.wr_back;
  assign wr_addr = cmd.wr_front ? front_dec : ring_pos;
  assign rd_en   = cmd.rd_front | cmd.rd_back | cmd.rd_dump;
  assign rd_addr = cmd.rd_front ? front_r : ring_pos;

  always_comb begin
    front_nxt = front_r;
    if (cmd.wr_front) begin
      front_nxt = front_dec;
    end else if (cmd.rm_front) begin
      front_nxt = ring_pos;
    end
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rm_front | cmd.rm_back) begin
      count_nxt = count_r - CW'(1);
    end
    dcnt_nxt = dcnt_r;
    if (cmd.load) begin
      dcnt_nxt = '0;
    end else if (cmd.rd_dump) begin
      dcnt_nxt = dcnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      value_r <= in_value;
    end
    if (cmd.emit) begin
      out_value_r  <= cmd.emit_data ? rd_data_r : '0;
      out_status_r <= cmd.emit_status;
      out_count_r  <= count_nxt;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign stat.op        = op_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.dump_last = (dcnt_r == count_r);

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;
  assign out_last_of_run  = out_last_r;

endmodule

### hdl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for one deque operation: decode, memory read wait, dump run.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bdq_pkg::bdq_stat_t  stat,
  output bdq_pkg::bdq_cmd_t   cmd,
  output logic                busy
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_POPOUT = 2'd2;
  localparam logic [1:0] S_DUMP   = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        cmd.emit_last = 1'b1;
        case (stat.op)
          bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
            cmd.emit = 1'b1;
            if (stat.full) begin
              cmd.emit_status = bdq_pkg::ST_FULL;
            end else begin
              cmd.emit_status = bdq_pkg::ST_OK;
              cmd.wr_front    = (stat.op == bdq_pkg::OP_PUSH_FRONT);
              cmd.wr_back     = (stat.op == bdq_pkg::OP_PUSH_BACK);
            end
          end
          bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bdq_pkg::ST_EMPTY;
            end else begin
              cmd.rd_front = (stat.op == bdq_pkg::OP_POP_FRONT);
              cmd.rm_front = (stat.op == bdq_pkg::OP_POP_FRONT);
              cmd.rd_back  = (stat.op == bdq_pkg::OP_POP_BACK);
              cmd.rm_back  = (stat.op == bdq_pkg::OP_POP_BACK);
              state_nxt    = S_POPOUT;
            end
          end
          bdq_pkg::OP_DUMP: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bdq_pkg::ST_EMPTY;
            end else begin
              cmd.rd_dump = 1'b1;
              state_nxt   = S_DUMP;
            end
          end
          default: begin
            // undefined opcode: no-op, report ok
            cmd.emit        = 1'b1;
            cmd.emit_status = bdq_pkg::ST_OK;
          end
        endcase
      end
      S_POPOUT: begin
        cmd.emit        = 1'b1;
        cmd.emit_data   = 1'b1;
        cmd.emit_status = bdq_pkg::ST_OK;
        cmd.emit_last   = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_DUMP: begin
        // show entry read last cycle, fetch the next one behind it
        cmd.emit        = 1'b1;
        cmd.emit_data   = 1'b1;
        cmd.emit_status = bdq_pkg::ST_OK;
        cmd.emit_last   = stat.dump_last;
        if (stat.dump_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_dump = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hdl/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of signed words in a DEPTH-entry ring store.
//
//   channel  handshake          payload
//   in       start / busy       in_opcode, in_value
//   out      out_valid strobe   out_result_value, out_status,
//                               out_entry_count, out_last_of_run
//
// A transfer in happens when start is high and busy is low. Push and
// refused/empty operations pass through the idle and execute states, pops
// add a state for the registered store read, and a dump shows one entry
// per cycle from the single read port. Results leave through a register
// and are held for one cycle only; the receiver cannot stall.
// Synchronous reset empties the queue; the store itself is not cleared.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_result_value,
  output logic [1:0]                   out_status,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count,
  output logic                         out_last_of_run
);

  localparam int CW = $clog2(DEPTH + 1);

  bdq_pkg::bdq_cmd_t  cmd;
  bdq_pkg::bdq_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_last_of_run  (out_last_of_run)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=> out_valid)
    else $error("dump run broken before its last entry");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bdq_pkg::ST_FULL) |-> out_entry_count == CW'(DEPTH))
    else $error("full status with queue not full");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bdq_pkg::ST_EMPTY)
      |-> (out_entry_count == '0 && out_result_value == '0 && out_last_of_run))
    else $error("empty status with bad count, value or last flag");

endmodule

### test/bounded_double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_tb
// Self-checking bench for the ring-store deque. Commands are sent over the
// start/busy port with random idle gaps, and a scoreboard keeps its own
// deque model to predict every result run. Directed commands cover the
// empty, full, reserved-opcode and extreme-value cases. Random traffic
// then alternates between fill-biased and drain-biased mixes.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_tb;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int RAND_ITEMS = 356;
  localparam int IDLE_LIMIT = 2000;

  // opcodes 5..7 are not decoded and act as no-ops
  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic [1:0]                   status;
    logic [CW-1:0]                count;
    logic                         last;
  } deque_result_t;

  class deque_scoreboard;
    deque_result_t                pending_q[$];
    logic signed [DATA_WIDTH-1:0] ring[DEPTH];
    int unsigned                  head;
    int unsigned                  fill;
    int                           errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function void add(logic signed [DATA_WIDTH-1:0] v, logic [1:0] st, logic lst);
      deque_result_t r;
      r.value  = v;
      r.status = st;
      r.count  = fill[CW-1:0];
      r.last   = lst;
      pending_q.push_back(r);
    endfunction

    // advance the model by one accepted command and queue its results
    function void note_transfer(logic [2:0] op, logic signed [DATA_WIDTH-1:0] val);
      logic signed [DATA_WIDTH-1:0] got;
      case (op)
        bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            add('0, bdq_pkg::ST_FULL, 1'b1);
          end else begin
            if (op == bdq_pkg::OP_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              ring[head] = val;
            end else begin
              ring[(head + fill) % DEPTH] = val;
            end
            fill++;
            add('0, bdq_pkg::ST_OK, 1'b1);
          end
        end
        bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
          if (fill == 0) begin
            add('0, bdq_pkg::ST_EMPTY, 1'b1);
          end else begin
            if (op == bdq_pkg::OP_POP_FRONT) begin
              got  = ring[head];
              head = (head + 1) % DEPTH;
            end else begin
              got = ring[(head + fill - 1) % DEPTH];
            end
            fill--;
            add(got, bdq_pkg::ST_OK, 1'b1);
          end
        end
        bdq_pkg::OP_DUMP: begin
          if (fill == 0) begin
            add('0, bdq_pkg::ST_EMPTY, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++)
              add(ring[(head + i) % DEPTH], bdq_pkg::ST_OK, i + 1 == fill);
          end
        end
        default: add('0, bdq_pkg::ST_OK, 1'b1);
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [DATA_WIDTH-1:0] v, logic [1:0] st,
                      logic [CW-1:0] cnt, logic lst);
      deque_result_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result value=%0d status=%0d count=%0d last=%0b",
                         v, st, cnt, lst));
        return;
      end
      e = pending_q.pop_front();
      if (v !== e.value || st !== e.status || cnt !== e.count || lst !== e.last)
        report($sformatf("got value=%0d status=%0d count=%0d last=%0b, want %0d/%0d/%0d/%0b",
                         v, st, cnt, lst, e.value, e.status, e.count, e.last));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [2:0]                   in_opcode = bdq_pkg::OP_PUSH_FRONT;
  logic signed [DATA_WIDTH-1:0] in_value = '0;
  logic                         out_valid;
  logic signed [DATA_WIDTH-1:0] out_result_value;
  logic [1:0]                   out_status;
  logic [CW-1:0]                out_entry_count;
  logic                         out_last_of_run;

  deque_scoreboard sb = new();
  int              idle_cycles = 0;

  bounded_double_ended_queue #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_result_value(out_result_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_result_value, out_status, out_entry_count, out_last_of_run);
  end

  // watchdog: cycles with neither a command transfer nor a result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_valid === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // one command transfer, preceded by a random idle gap
  task automatic send_cmd(logic [2:0] op, logic signed [DATA_WIDTH-1:0] val,
                          int idle_pct);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_transfer(op, val);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      return 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    if (r < 11)
      return bdq_pkg::OP_DUMP;
    if (r < (filling ? 75 : 35))
      return $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
    return $urandom_range(0, 1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
  endfunction

  initial begin
    int idle_mix[4];
    bit filling;
    idle_mix = '{0, 64, 0, 21};
    filling  = 1'b1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty-queue cases and a reserved opcode
    send_cmd(bdq_pkg::OP_DUMP, WORD_MAX, 0);
    send_cmd(bdq_pkg::OP_POP_FRONT, WORD_MIN, 0);
    send_cmd(bdq_pkg::OP_POP_BACK, '1, 0);
    send_cmd(OP_RESERVED_LO, $urandom, 0);
    // extremes, then fill to capacity through the ring wrap
    send_cmd(bdq_pkg::OP_PUSH_FRONT, WORD_MIN, 0);
    send_cmd(bdq_pkg::OP_PUSH_BACK, WORD_MAX, 0);
    send_cmd(bdq_pkg::OP_PUSH_FRONT, '1, 0);
    send_cmd(bdq_pkg::OP_PUSH_BACK, '0, 0);
    for (int i = 0; i < DEPTH - 4; i++)
      send_cmd(i[0] ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT, $urandom, 0);
    send_cmd(bdq_pkg::OP_PUSH_FRONT, $urandom, 0);
    send_cmd(bdq_pkg::OP_PUSH_BACK, $urandom, 0);
    send_cmd(bdq_pkg::OP_DUMP, '0, 0);
    send_cmd(bdq_pkg::OP_POP_FRONT, '0, 0);
    send_cmd(bdq_pkg::OP_POP_BACK, '0, 0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        if (sb.fill == DEPTH && $urandom_range(0, 99) < 30)
          filling = 1'b0;
        else if (sb.fill == 0 && $urandom_range(0, 99) < 30)
          filling = 1'b1;
        send_cmd(pick_op(filling), pick_value(), idle_mix[ph]);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bdq_pkg.sv
hdl/bdq_datapath.sv
hdl/bdq_ctrl.sv
hdl/bounded_double_ended_queue.sv
test/bounded_double_ended_queue_tb.sv
